>>> rtl/core/fhrl_pkg.sv
// Shared types and constants for the fingerprint hash rank lookup.
// Holds the beat structs, the command codes and the fixed field widths.
// No dependencies.
package fhrl_pkg;

    localparam int SLOT_INDEX_BITS = 14;
    localparam int SLOT_WORD_BITS  = 32;
    localparam int FP_BITS         = 24;
    localparam int RANK_BITS       = 8;
    localparam int CFG_INDEX_BITS  = 1;
    localparam int CFG_DATA_BITS   = 4;
    localparam int MIN_SIZE_LOG2   = 8;

    localparam logic [31:0] GOLDEN_MUL = 32'h9E37_79B9;

    localparam logic [CFG_INDEX_BITS-1:0] REG_TABLE_SIZE_LOG2 = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TABLE_VALID     = 1'b1;

    typedef struct packed {
        logic                       kind;
        logic [SLOT_INDEX_BITS-1:0] slot_index;
        logic [SLOT_WORD_BITS-1:0]  slot_value;
        logic [31:0]                hash_first;
        logic [31:0]                hash_second;
        logic                       word_empty;
    } in_item_t;

    typedef struct packed {
        logic                 found;
        logic [RANK_BITS-1:0] rank;
    } out_item_t;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_MISS   = 2'd2
    } cmd_op_t;

endpackage

>>> rtl/core/fhrl_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Read data holds its value while no read is issued. No dependencies.
module fhrl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/fhrl_queue.sv
// Two-entry command queue that separates the front from the back.
// Generic payload width. No dependencies.
module fhrl_queue #(
    parameter int WIDTH = 60
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop) begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign rdata     = entry_reg[rd_ptr_reg];

endmodule

>>> rtl/core/fhrl_front.sv
// Front end: accepts input beats and turns them into queue commands.
// Forms the fingerprint and the hashed start index. Depends on fhrl_pkg.
module fhrl_front import fhrl_pkg::*; #(
    parameter int SLOT_ADDR_BITS = 14
) (
    input  in_item_t                  s_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      table_valid,
    input  logic                      queue_full,
    output logic                      cmd_push,
    output cmd_op_t                   cmd_op,
    output logic [SLOT_ADDR_BITS-1:0] cmd_addr,
    output logic [SLOT_WORD_BITS-1:0] cmd_data
);

    logic [31:0]        product;
    logic [31:0]        start_hash;
    logic [FP_BITS-1:0] fp;

    assign product    = s_data.hash_second * GOLDEN_MUL;
    assign start_hash = product ^ (s_data.hash_first >> 7);

    always_comb begin
        fp = s_data.hash_first[FP_BITS-1:0];
        if (fp == '0) begin
            fp = FP_BITS'(1);
        end
        if (s_data.kind == KIND_WRITE) begin
            cmd_op   = CMD_WRITE;
            cmd_addr = SLOT_ADDR_BITS'(s_data.slot_index);
            cmd_data = s_data.slot_value;
        end else begin
            cmd_op   = (table_valid && !s_data.word_empty) ? CMD_LOOKUP : CMD_MISS;
            cmd_addr = start_hash[SLOT_ADDR_BITS-1:0];
            cmd_data = {{(SLOT_WORD_BITS-FP_BITS){1'b0}}, fp};
        end
    end

    assign s_ready  = !queue_full;
    assign cmd_push = s_valid && !queue_full;

endmodule

>>> rtl/core/fhrl_back.sv
// Back end: executes slot writes and probe sequences against the slot RAM.
// Owns the result register. Depends on fhrl_pkg and fhrl_ram.
module fhrl_back import fhrl_pkg::*; #(
    parameter int SLOT_ADDR_BITS = 14,
    parameter int MAX_PROBES     = 128
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [CFG_DATA_BITS-1:0]  size_log2,
    input  logic                      cmd_valid,
    input  cmd_op_t                   cmd_op,
    input  logic [SLOT_ADDR_BITS-1:0] cmd_addr,
    input  logic [SLOT_WORD_BITS-1:0] cmd_data,
    output logic                      cmd_pop,
    output logic                      m_valid,
    input  logic                      m_ready,
    output out_item_t                 m_data
);

    localparam int CNT_BITS = $clog2(MAX_PROBES + 1);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_PROBE = 2'b10
    } state_t;

    state_t                    state_reg, state_next;
    logic [SLOT_ADDR_BITS-1:0] idx_reg, idx_next;
    logic [CNT_BITS-1:0]       cnt_reg, cnt_next;
    logic [FP_BITS-1:0]        fp_reg, fp_next;
    logic                      m_valid_reg, m_valid_next;
    out_item_t                 m_data_reg, m_data_next;
    logic [SLOT_ADDR_BITS-1:0] mask;
    logic                      out_free;
    logic                      ram_we;
    logic                      ram_re;
    logic [SLOT_ADDR_BITS-1:0] ram_raddr;
    logic [SLOT_WORD_BITS-1:0] ram_rdata;
    logic                      slot_empty;
    logic                      slot_hit;

    fhrl_ram #(
        .WIDTH (SLOT_WORD_BITS),
        .DEPTH (2 ** SLOT_ADDR_BITS)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (cmd_addr),
        .wdata (cmd_data),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        for (int i = 0; i < SLOT_ADDR_BITS; i++) begin
            mask[i] = (i < MIN_SIZE_LOG2) || (i < int'(size_log2));
        end
    end

    assign out_free   = !m_valid_reg || m_ready;
    assign slot_empty = (ram_rdata == '0);
    assign slot_hit   = (ram_rdata[FP_BITS-1:0] == fp_reg);

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        cnt_next     = cnt_reg;
        fp_next      = fp_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        cmd_pop      = 1'b0;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_raddr    = idx_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid && out_free) begin
                    cmd_pop = 1'b1;
                    case (cmd_op)
                        CMD_WRITE: begin
                            ram_we       = 1'b1;
                            m_valid_next = 1'b1;
                            m_data_next  = '{found: 1'b0, rank: '0};
                        end
                        CMD_LOOKUP: begin
                            ram_re     = 1'b1;
                            ram_raddr  = cmd_addr & mask;
                            idx_next   = cmd_addr & mask;
                            cnt_next   = '0;
                            fp_next    = cmd_data[FP_BITS-1:0];
                            state_next = ST_PROBE;
                        end
                        default: begin
                            m_valid_next = 1'b1;
                            m_data_next  = '{found: 1'b0, rank: '0};
                        end
                    endcase
                end
            end
            ST_PROBE: begin
                if (slot_empty || slot_hit || cnt_reg == CNT_BITS'(MAX_PROBES - 1)) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        if (!slot_empty && slot_hit) begin
                            m_data_next = '{found: 1'b1,
                                            rank: ram_rdata[SLOT_WORD_BITS-1 -: RANK_BITS]};
                        end else begin
                            m_data_next = '{found: 1'b0, rank: '0};
                        end
                        state_next = ST_IDLE;
                    end
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = (idx_reg + SLOT_ADDR_BITS'(1)) & mask;
                    idx_next  = (idx_reg + SLOT_ADDR_BITS'(1)) & mask;
                    cnt_next  = cnt_reg + CNT_BITS'(1);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        cnt_reg    <= cnt_next;
        fp_reg     <= fp_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> rtl/core/fingerprint_hash_rank_lookup.sv
// Top level of the fingerprint hash rank lookup: config registers, front, queue, back.
// Depends on fhrl_pkg, fhrl_front, fhrl_queue and fhrl_back.
//
//   Channel   Ports                        Beat
//   input     s_valid, s_ready, s_data     one write or lookup item
//   result    m_valid, m_ready, m_data     found flag and rank
//   config    cfg_we, cfg_index, cfg_wdata register write, no handshake
//
// A write or an early miss is handled by the back end without a probe; a lookup
// reads one slot per probe from the hashed start index, up to MAX_PROBES probes,
// through the single read port of the slot RAM. The front and the two-entry queue
// keep taking beats while the back end probes or waits on m_ready, until the queue
// is full. Reset is synchronous and active low; the slot RAM is not cleared.
module fingerprint_hash_rank_lookup import fhrl_pkg::*; #(
    parameter int SLOT_ADDR_BITS = 14,
    parameter int MAX_PROBES     = 128
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  in_item_t                  s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output out_item_t                 m_data,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata
);

    localparam int CMD_W = $bits(cmd_op_t) + SLOT_ADDR_BITS + SLOT_WORD_BITS;

    logic [CFG_DATA_BITS-1:0]  size_log2_reg;
    logic                      table_valid_reg;
    logic                      queue_full;
    logic                      cmd_push;
    cmd_op_t                   front_op;
    logic [SLOT_ADDR_BITS-1:0] front_addr;
    logic [SLOT_WORD_BITS-1:0] front_data;
    logic                      cmd_pop;
    logic                      cmd_valid;
    logic [CMD_W-1:0]          queue_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_log2_reg   <= CFG_DATA_BITS'(14);
            table_valid_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_TABLE_SIZE_LOG2: begin
                    size_log2_reg <= cfg_wdata;
                end
                REG_TABLE_VALID: begin
                    table_valid_reg <= cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    fhrl_front #(
        .SLOT_ADDR_BITS (SLOT_ADDR_BITS)
    ) u_front (
        .s_data      (s_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .table_valid (table_valid_reg),
        .queue_full  (queue_full),
        .cmd_push    (cmd_push),
        .cmd_op      (front_op),
        .cmd_addr    (front_addr),
        .cmd_data    (front_data)
    );

    fhrl_queue #(
        .WIDTH (CMD_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (cmd_push),
        .wdata     ({front_op, front_addr, front_data}),
        .full      (queue_full),
        .pop       (cmd_pop),
        .not_empty (cmd_valid),
        .rdata     (queue_out)
    );

    fhrl_back #(
        .SLOT_ADDR_BITS (SLOT_ADDR_BITS),
        .MAX_PROBES     (MAX_PROBES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .size_log2 (size_log2_reg),
        .cmd_valid (cmd_valid),
        .cmd_op    (cmd_op_t'(queue_out[CMD_W-1 -: $bits(cmd_op_t)])),
        .cmd_addr  (queue_out[SLOT_WORD_BITS +: SLOT_ADDR_BITS]),
        .cmd_data  (queue_out[SLOT_WORD_BITS-1:0]),
        .cmd_pop   (cmd_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
